[sv/ssw_pkg.sv]
// types, constants and helper functions shared by the sync-write framer
`timescale 1ns / 1ps

package ssw_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_ID           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSTRUCTION_CODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGISTER_ADDRESS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_BYTES       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_COUNT      = 3'd4;

   localparam logic [7:0] RST_BUS_ID           = 8'd254;
   localparam logic [7:0] RST_INSTRUCTION_CODE = 8'd131;
   localparam logic [7:0] RST_REGISTER_ADDRESS = 8'd42;
   localparam logic [1:0] RST_DATA_BYTES       = 2'd2;
   localparam logic [5:0] RST_MOTOR_COUNT      = 6'd6;

   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd4;
   localparam logic [7:0] NBYTES_ONE   = 8'h01;
   localparam logic [7:0] NBYTES_TWO   = 8'h02;

   typedef struct packed {
      logic [7:0]  motor_id;
      logic [15:0] motor_value;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       frame_end;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] bus_id;
      logic [7:0] instruction_code;
      logic [7:0] register_address;
      logic [1:0] data_bytes;
      logic [5:0] motor_count;
   } cfg_type;

   // one classified motor entry waiting for the byte sequencer
   typedef struct packed {
      logic [7:0]  motor_id;
      logic [15:0] motor_value;
      logic        first;
      logic        last;
   } entry_type;

   // motor count of zero counts as one
   function automatic logic [5:0] eff_count(input logic [5:0] motor_count);
      eff_count = (motor_count == 6'd0) ? 6'd1 : motor_count;
   endfunction

   // zero or one data bytes means one, two or three means two
   function automatic logic two_bytes(input logic [1:0] data_bytes);
      two_bytes = data_bytes[1];
   endfunction

endpackage

[sv/ssw_front.sv]
// front end: accepts motor entries and tags the first and last of each frame
`timescale 1ns / 1ps

module ssw_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               queue_full,
   input  ssw_pkg::req_type   req_payload,
   input  ssw_pkg::cfg_type   cfg,
   output logic               push,
   output ssw_pkg::entry_type entry
);
   import ssw_pkg::*;

   logic [5:0] entry_index_ff;
   logic [5:0] entry_index_in;
   logic [5:0] count;
   logic [6:0] next_index;
   logic       last;

   assign count      = eff_count(cfg.motor_count);
   assign next_index = {1'b0, entry_index_ff} + 7'd1;
   assign last       = next_index >= {1'b0, count};
   assign push       = req_valid & ~queue_full;

   always_comb begin
      entry.motor_id    = req_payload.motor_id;
      entry.motor_value = req_payload.motor_value;
      entry.first       = entry_index_ff == 6'd0;
      entry.last        = last;
   end

   always_comb begin
      entry_index_in = entry_index_ff;
      if (push) begin
         entry_index_in = last ? 6'd0 : next_index[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_index_ff <= 6'd0;
      end else begin
         entry_index_ff <= entry_index_in;
      end
   end

endmodule

[sv/ssw_queue.sv]
// short entry queue between the front end and the byte sequencer
`timescale 1ns / 1ps

module ssw_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssw_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output ssw_pkg::entry_type head
);
   import ssw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/ssw_back.sv]
// back end: walks the packet bytes of each entry into the output register
`timescale 1ns / 1ps

module ssw_back (
   input  logic               clock,
   input  logic               reset,
   input  ssw_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  ssw_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ssw_pkg::rsp_type   rsp_payload
);
   import ssw_pkg::*;

   localparam logic [3:0] ST_START  = 4'd0;
   localparam logic [3:0] ST_SYNC0  = 4'd1;
   localparam logic [3:0] ST_SYNC1  = 4'd2;
   localparam logic [3:0] ST_ID     = 4'd3;
   localparam logic [3:0] ST_LEN    = 4'd4;
   localparam logic [3:0] ST_INSTR  = 4'd5;
   localparam logic [3:0] ST_ADDR   = 4'd6;
   localparam logic [3:0] ST_NBYTES = 4'd7;
   localparam logic [3:0] ST_MID    = 4'd8;
   localparam logic [3:0] ST_LO     = 4'd9;
   localparam logic [3:0] ST_HI     = 4'd10;
   localparam logic [3:0] ST_CHK    = 4'd11;

   logic [3:0] step_ff;
   logic [3:0] step_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_payload_ff;
   rsp_type    rsp_payload_in;

   logic [3:0] cur;
   logic [3:0] next;
   logic       done;
   logic       load;
   logic       two;
   logic [7:0] cnt8;
   logic [7:0] len;
   rsp_type    beat;

   assign two  = two_bytes(cfg.data_bytes);
   assign cnt8 = {2'b00, eff_count(cfg.motor_count)};
   assign len  = (two ? cnt8 + (cnt8 << 1) : cnt8 << 1) + LEN_OVERHEAD;
   assign cur  = (step_ff == ST_START) ? (head.first ? ST_SYNC0 : ST_MID) : step_ff;
   assign load = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop  = load & done;

   always_comb begin
      beat.bus_byte  = SYNC_BYTE;
      beat.frame_end = 1'b0;
      beat.run_end   = 1'b0;
      next           = ST_START;
      done           = 1'b0;
      case (cur)
         ST_SYNC0: begin
            next = ST_SYNC1;
         end
         ST_SYNC1: begin
            next = ST_ID;
         end
         ST_ID: begin
            beat.bus_byte = cfg.bus_id;
            next          = ST_LEN;
         end
         ST_LEN: begin
            beat.bus_byte = len;
            next          = ST_INSTR;
         end
         ST_INSTR: begin
            beat.bus_byte = cfg.instruction_code;
            next          = ST_ADDR;
         end
         ST_ADDR: begin
            beat.bus_byte = cfg.register_address;
            next          = ST_NBYTES;
         end
         ST_NBYTES: begin
            beat.bus_byte = two ? NBYTES_TWO : NBYTES_ONE;
            next          = ST_MID;
         end
         ST_MID: begin
            beat.bus_byte = head.motor_id;
            next          = ST_LO;
         end
         ST_LO: begin
            beat.bus_byte = head.motor_value[7:0];
            if (two) begin
               next = ST_HI;
            end else if (head.last) begin
               next = ST_CHK;
            end else begin
               done         = 1'b1;
               beat.run_end = 1'b1;
            end
         end
         ST_HI: begin
            beat.bus_byte = head.motor_value[15:8];
            if (head.last) begin
               next = ST_CHK;
            end else begin
               done         = 1'b1;
               beat.run_end = 1'b1;
            end
         end
         ST_CHK: begin
            beat.bus_byte  = ~sum_ff;
            beat.frame_end = 1'b1;
            beat.run_end   = 1'b1;
            done           = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in        = step_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         step_in        = done ? ST_START : next;
         rsp_valid_in   = 1'b1;
         rsp_payload_in = beat;
         case (cur)
            ST_SYNC0, ST_SYNC1: sum_in = sum_ff;
            ST_ID:              sum_in = beat.bus_byte;
            ST_CHK:             sum_in = 8'd0;
            default:            sum_in = sum_ff + beat.bus_byte;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_START;
         sum_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.frame_end |-> rsp_payload_ff.run_end)
      else $error("frame end without run end");

   a_active_has_head: assert property (@(posedge clock) disable iff (reset)
      step_ff != ST_START |-> head_valid)
      else $error("sequencer mid entry with empty queue");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_CHK)
      else $error("sequencer step out of range");

   a_pop_after_chk_clears_sum: assert property (@(posedge clock) disable iff (reset)
      load && cur == ST_CHK |=> sum_ff == 8'd0 && step_ff == ST_START)
      else $error("checksum byte did not close the frame");
`endif

endmodule

[sv/servo_sync_write_framer.sv]
// top level of the servo-bus sync-write packet framer
`timescale 1ns / 1ps

// Each accepted motor transaction turns into packet bytes on the rsp channel, one byte
// per clock from the byte sequencer's output register unless rsp_stall holds it or
// the queue is empty. A frame's first entry emits the seven header bytes before its
// id and data, its last entry appends the checksum, so an entry gives 2 to 11 bytes:
// 2 or 3 (id and one or two data bytes) plus 7 header and 1 checksum. The entry queue
// lets new transactions be taken while bytes are still going out. The user must write
// the configuration registers via the csr port while idle; the block does not check.

module servo_sync_write_framer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ssw_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ssw_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_en,
   input  logic [ssw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ssw_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ssw_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      head_valid;
   entry_type push_entry;
   entry_type head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BUS_ID:           cfg_in.bus_id           = csr_wdata;
            CSR_INSTRUCTION_CODE: cfg_in.instruction_code = csr_wdata;
            CSR_REGISTER_ADDRESS: cfg_in.register_address = csr_wdata;
            CSR_DATA_BYTES:       cfg_in.data_bytes       = csr_wdata[1:0];
            CSR_MOTOR_COUNT:      cfg_in.motor_count      = csr_wdata[5:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_id           <= RST_BUS_ID;
         cfg_ff.instruction_code <= RST_INSTRUCTION_CODE;
         cfg_ff.register_address <= RST_REGISTER_ADDRESS;
         cfg_ff.data_bytes       <= RST_DATA_BYTES;
         cfg_ff.motor_count      <= RST_MOTOR_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;

   ssw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .queue_full  (queue_full),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .push        (push),
      .entry       (push_entry)
   );

   ssw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   ssw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
